// File: design/ssi_pkg.sv
package ssi_pkg;

    localparam int INDEX_WIDTH = 31;
    localparam int COORD_W     = 16;

    // two radicand bits retire per root step
    localparam int SQ_STEPS = (INDEX_WIDTH + 1) / 2;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int REM_W    = ROOT_W + 1;
    localparam int M_W      = ROOT_W + 3;
    localparam int CNT_W    = $clog2(SQ_STEPS);

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sq_res_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;
    } coord_t;

endpackage

// File: design/square_spiral_index_to_coord_core.sv
// Spiral index to (row, col) converter, one item in flight at a time.
// Each index runs through the two-bit-per-cycle square root followed by a
// three-step divide by the ring size.
// A new input beat is taken while the previous result waits in the output register.
// Reset (rst_n, async, active low) empties the pipeline and drops out_valid.
module square_spiral_index_to_coord_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ssi_pkg::INDEX_WIDTH-1:0]  spiral_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [ssi_pkg::COORD_W-1:0] row,
    output logic signed [ssi_pkg::COORD_W-1:0] col
);

    localparam int INDEX_WIDTH = ssi_pkg::INDEX_WIDTH;
    localparam int RAD_W       = ssi_pkg::RAD_W;
    localparam int COORD_W     = ssi_pkg::COORD_W;

    typedef enum logic [1:0] {ST_IDLE, ST_ROOT, ST_SIDE, ST_HOLD} state_t;

    state_t                     state_reg;
    logic                       center_reg;
    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  row_reg;
    logic signed [COORD_W-1:0]  col_reg;

    logic                       accept;
    logic                       load_out;
    logic [INDEX_WIDTH-1:0]     idx_m1;
    logic                       sq_done;
    ssi_pkg::sq_res_t           sq_res;
    logic                       sd_start;
    logic                       sd_done;
    ssi_pkg::coord_t            sd_coord;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign idx_m1   = spiral_index - INDEX_WIDTH'(1);
    assign sd_start = (state_reg == ST_ROOT) && sq_done;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || !out_stall);

    ssi_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .radicand (RAD_W'(idx_m1)),
        .done     (sq_done),
        .res      (sq_res)
    );

    ssi_side u_side
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sd_start),
        .center (center_reg),
        .sq     (sq_res),
        .done   (sd_done),
        .coord  (sd_coord)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // index 0 and 1 both land on the center
                        center_reg <= (spiral_index < INDEX_WIDTH'(2));
                        state_reg  <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_SIDE;
                    end
                end
                ST_SIDE:
                begin
                    if (sd_done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (load_out)
                    begin
                        row_reg   <= sd_coord.row;
                        col_reg   <= sd_coord.col;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign col       = col_reg;

`ifndef SYNTH
    a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == ST_ROOT))
        else $error("root done outside root phase");

    a_side_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sd_done |-> (state_reg == ST_SIDE))
        else $error("side done outside side phase");

    a_hold_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && out_valid_reg && out_stall) |=> (state_reg == ST_HOLD))
        else $error("result overwrote a stalled output beat");
`endif

endmodule

// File: design/ssi_sqrt.sv
module ssi_sqrt
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ssi_pkg::RAD_W-1:0] radicand,
    output logic                     done,
    output ssi_pkg::sq_res_t         res
);

    localparam int ROOT_W = ssi_pkg::ROOT_W;
    localparam int REM_W  = ssi_pkg::REM_W;
    localparam int RAD_W  = ssi_pkg::RAD_W;
    localparam int CNT_W  = ssi_pkg::CNT_W;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  cand;
    logic [ROOT_W+3:0] trial;
    logic              neg;
    logic              last;

    // next radicand digit joins the partial remainder; try root*4+1
    assign cand  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {1'b0, cand} - {2'b00, root_reg, 2'b01};
    assign neg   = trial[ROOT_W+3];
    assign last  = (cnt_reg == CNT_W'(ssi_pkg::SQ_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= neg ? cand[REM_W-1:0] : trial[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ~neg};
        end
    end

    assign done     = done_reg;
    assign res.root = root_reg;
    assign res.rem  = rem_reg;

endmodule

// File: design/ssi_side.sv
module ssi_side
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             center,
    input  ssi_pkg::sq_res_t sq,
    output logic             done,
    output ssi_pkg::coord_t  coord
);

    localparam int ROOT_W  = ssi_pkg::ROOT_W;
    localparam int M_W     = ssi_pkg::M_W;
    localparam int COORD_W = ssi_pkg::COORD_W;

    localparam logic [2:0] SIDE_RIGHT  = 3'd0;
    localparam logic [2:0] SIDE_TOP    = 3'd1;
    localparam logic [2:0] SIDE_LEFT   = 3'd2;
    localparam logic [2:0] SIDE_BOTTOM = 3'd3;

    localparam logic [1:0] LAST_STEP = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MAP} state_t;

    state_t            state_reg;
    logic [1:0]        step_reg;
    logic [ROOT_W-1:0] ring_reg;
    logic [M_W-1:0]    m_reg;
    logic [M_W-1:0]    dsh_reg;
    logic [2:0]        side_reg;
    logic              center_reg;
    logic              done_reg;
    ssi_pkg::coord_t   coord_reg;

    logic [ROOT_W-1:0] ring_next;
    logic [M_W-1:0]    m_next;
    logic              ge;
    logic [COORD_W-1:0] r16;
    logic [COORD_W-1:0] p16;
    ssi_pkg::coord_t   coord_next;

    // root s of index-1: odd s -> inner side s, even s -> inner side s-1
    assign ring_next = (sq.root >> 1) + ROOT_W'(sq.root[0]);
    assign m_next    = sq.root[0] ? (M_W'(sq.rem) + M_W'(1))
                                  : (M_W'(sq.rem) + M_W'({sq.root, 1'b0}));

    assign ge  = (m_reg >= dsh_reg);
    assign r16 = COORD_W'(ring_reg);
    assign p16 = COORD_W'(m_reg);

    always_comb
    begin
        coord_next.row = '0;
        coord_next.col = '0;
        if (!center_reg)
        begin
            case (side_reg)
                SIDE_RIGHT:
                begin
                    coord_next.col = r16;
                    coord_next.row = p16 - r16;
                end
                SIDE_TOP:
                begin
                    coord_next.row = r16;
                    coord_next.col = r16 - p16;
                end
                SIDE_LEFT:
                begin
                    coord_next.col = -r16;
                    coord_next.row = r16 - p16;
                end
                SIDE_BOTTOM:
                begin
                    coord_next.row = -r16;
                    coord_next.col = p16 - r16;
                end
                default:
                begin
                    // closing corner of the ring
                    coord_next.row = -r16;
                    coord_next.col = r16;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        ring_reg   <= ring_next;
                        m_reg      <= m_next;
                        dsh_reg    <= {ring_next, 3'b000};
                        side_reg   <= '0;
                        center_reg <= center;
                        step_reg   <= '0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // restoring divide by 2*ring, three quotient bits
                    if (ge)
                    begin
                        m_reg <= m_reg - dsh_reg;
                    end
                    side_reg <= {side_reg[1:0], ge};
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_MAP;
                    end
                end
                ST_MAP:
                begin
                    coord_reg <= coord_next;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign coord = coord_reg;

endmodule
